// File: design/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define KF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define KF_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KF_IMPLY_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/kf_pkg.sv
// Types, constants and saturation helpers for the position/velocity Kalman filter.
package kf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int WIDE_BITS = WORD_BITS + 3;
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int CFG_IDX_W = 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-2:0]        var_t;
	typedef logic signed [WIDE_BITS-1:0] wide_t;

	localparam word_t UNITY     = word_t'(1) <<< FRAC_BITS;
	localparam word_t RESET_VAR = word_t'(1000) <<< FRAC_BITS;
	localparam wide_t SMAX_W    = wide_t'({1'b0, {(WORD_BITS-1){1'b1}}});
	localparam wide_t SMIN_W    = -SMAX_W - wide_t'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEAS_VAR     = 3'd0,
		REG_PROC_VAR_POS = 3'd1,
		REG_PROC_COV     = 3'd2,
		REG_PROC_VAR_VEL = 3'd3,
		REG_DRIVE_POS    = 3'd4,
		REG_DRIVE_VEL    = 3'd5,
		REG_STEP_DT      = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LD0, ST_DIV0, ST_LD1, ST_DIV1, ST_MUL, ST_RND, ST_WB, ST_OUT
	} kf_state_t;

	// Micro-ops: one multiply each, followed by a writeback.
	typedef enum logic [3:0] {
		OP_XPOS_UPD, OP_XVEL_UPD, OP_P00_UPD, OP_P01_UPD, OP_P11_UPD,
		OP_XPOS_PRED, OP_T_PRED, OP_P00_PART, OP_P_PRED
	} kf_op_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} sat_res_t;

	typedef sat_res_t div_res_t;

	function automatic sat_res_t sat_s(wide_t v);
		sat_res_t r;
		if (v > SMAX_W) begin
			r.sat = 1'b1;
			r.val = word_t'(SMAX_W);
		end else if (v < SMIN_W) begin
			r.sat = 1'b1;
			r.val = word_t'(SMIN_W);
		end else begin
			r.sat = 1'b0;
			r.val = word_t'(v);
		end
		return r;
	endfunction

	function automatic sat_res_t sat_v(wide_t v);
		sat_res_t r;
		if (v > SMAX_W) begin
			r.sat = 1'b1;
			r.val = word_t'(SMAX_W);
		end else if (v < wide_t'(0)) begin
			r.sat = 1'b1;
			r.val = '0;
		end else begin
			r.sat = 1'b0;
			r.val = word_t'(v);
		end
		return r;
	endfunction

endpackage

// File: design/kf_div.sv
// Restoring divider for the gain: round(num * 2^FRAC_BITS / den), one bit per cycle.
`include "assert_macros.svh"
module kf_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  kf_pkg::word_t    num,
	input  logic [kf_pkg::WORD_BITS-1:0] den,
	output logic             done,
	output kf_pkg::div_res_t res
);
	import kf_pkg::*;

	localparam int NW = WORD_BITS + FRAC_BITS + 1;

	logic                 busy_q, done_q, neg_q, ov_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] rem_q, nlo_q, quo_q;

	logic [WORD_BITS-1:0] un, lim, qv;
	logic [NW-1:0]        nfull;
	logic [WORD_BITS-1:0] nhi;
	logic                 over;
	logic [WORD_BITS:0]   r2;
	logic                 ge;

	always_comb begin
		un    = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
		nfull = (NW'(un) << FRAC_BITS) + NW'(den >> 1);
		nhi   = WORD_BITS'(nfull[NW-1:WORD_BITS]);
		over  = nhi >= den;
		r2    = {rem_q, nlo_q[WORD_BITS-1]};
		ge    = r2 >= {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WORD_BITS-1];
			ov_q  <= over;
			rem_q <= over ? '0 : nhi;
			nlo_q <= nfull[WORD_BITS-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? WORD_BITS'(r2 - {1'b0, den}) : r2[WORD_BITS-1:0];
			nlo_q <= nlo_q << 1;
			quo_q <= {quo_q[WORD_BITS-2:0], ge};
		end
	end

	// sign and clamp
	always_comb begin
		lim = neg_q ? (WORD_BITS'(1) << (WORD_BITS-1))
		            : ((WORD_BITS'(1) << (WORD_BITS-1)) - WORD_BITS'(1));
		res.sat = ov_q || (quo_q > lim);
		qv      = res.sat ? lim : quo_q;
		res.val = neg_q ? word_t'(-qv) : word_t'(qv);
	end

	assign done = done_q;

	`KF_IMPLY(a_div_no_restart, start, !busy_q, "divider started while busy")
endmodule

// File: design/kalman_filter_pos_vel.sv
// Top level of the one-axis constant-velocity Kalman filter.
// One position measurement per input beat produces one output beat holding the
// predicted position, velocity and covariance (P00, P01, P11) in Q16.16, all
// signed but the unsigned 31-bit P00 and P11. Each measurement first runs the
// scalar measurement update (gains P00/S and P01/S with S = P00 + R, then state
// and covariance correction) and then the prediction with F = [1 dt; 0 1],
// drive offsets and symmetric process noise. Every clamp to the word range
// (variances to 0..2^31-1) and a zero S, which skips the update, raise sat_flag
// for that beat. One serial divider (one quotient bit per cycle) forms both
// gains and one 32x32 multiplier serves all nine multiplies. An item runs two
// divides, nine multiply/round/writeback triplets, and load and handoff
// states; a skipped update drops the divides and five update multiplies.
// in_ready is low while an item is in progress. The finished result sits in
// an output register, so the next measurement can be taken while it waits
// for out_ready. Configuration writes are meant for idle periods only.
`include "assert_macros.svh"
module kalman_filter_pos_vel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  kf_pkg::word_t                 cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kf_pkg::word_t                 meas_pos,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kf_pkg::word_t                 est_pos,
	output kf_pkg::word_t                 est_vel,
	output kf_pkg::var_t                  out_var_pos,
	output kf_pkg::word_t                 out_cov,
	output kf_pkg::var_t                  out_var_vel,
	output logic                          sat_flag
);
	import kf_pkg::*;

	// configuration
	var_t  meas_var_q, pvp_q, pvv_q;
	word_t pcov_q, dpos_q, dvel_q, dt_q;

	// filter state
	word_t x0_q, x1_q, p00_q, p01_q, p11_q;

	// working registers
	kf_state_t            st_q, st_d;
	kf_op_t               op_q;
	logic                 flag_q;
	word_t                k0_q, k1_q, y_q, t_q, m_q;
	wide_t                acc_q;
	logic [WORD_BITS-1:0] s_q;
	logic [PROD_BITS-1:0] prod_s1;
	logic                 neg_s1;

	// output register
	logic  out_valid_q, sat_flag_q;
	word_t est_pos_q, est_vel_q, out_cov_q;
	var_t  out_var_pos_q, out_var_vel_q;

	logic                 accept, div_start, div_done, out_load;
	word_t                div_num;
	div_res_t             div_res;
	logic [WORD_BITS-1:0] s_new;
	sat_res_t             y_new;

	word_t                ma_w, mb_w;
	logic [WORD_BITS-1:0] ma, mb;
	logic [PROD_BITS-1:0] rnd, lim, mq;
	logic                 msat;

	wide_t    base, addc, wm, main_sum;
	logic     sub;
	sat_res_t ss, sv, ax1, ap01, ap11;

	kf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.res    (div_res)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_var_q <= var_t'(UNITY);
			pvp_q      <= '0;
			pcov_q     <= '0;
			pvv_q      <= '0;
			dpos_q     <= '0;
			dvel_q     <= '0;
			dt_q       <= UNITY;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MEAS_VAR:     meas_var_q <= cfg_data[WORD_BITS-2:0];
				REG_PROC_VAR_POS: pvp_q      <= cfg_data[WORD_BITS-2:0];
				REG_PROC_COV:     pcov_q     <= cfg_data;
				REG_PROC_VAR_VEL: pvv_q      <= cfg_data[WORD_BITS-2:0];
				REG_DRIVE_POS:    dpos_q     <= cfg_data;
				REG_DRIVE_VEL:    dvel_q     <= cfg_data;
				REG_STEP_DT:      dt_q       <= cfg_data;
				default:          ;
			endcase
		end
	end

	// innovation variance and innovation, formed on the input beat
	always_comb begin
		s_new = {1'b0, p00_q[WORD_BITS-2:0]} + {1'b0, meas_var_q};
		y_new = sat_s(wide_t'(meas_pos) - wide_t'(x0_q));
	end

	// sequencer: next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid) begin
				st_d = (s_new == '0) ? ST_MUL : ST_LD0;
			end
			ST_LD0:  st_d = ST_DIV0;
			ST_DIV0: if (div_done) begin
				st_d = ST_LD1;
			end
			ST_LD1:  st_d = ST_DIV1;
			ST_DIV1: if (div_done) begin
				st_d = ST_MUL;
			end
			ST_MUL:  st_d = ST_RND;
			ST_RND:  st_d = ST_WB;
			ST_WB:   st_d = (op_q == OP_P_PRED) ? ST_OUT : ST_MUL;
			ST_OUT:  if (!out_valid_q || out_ready) begin
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready  = (st_q == ST_IDLE);
		div_start = (st_q == ST_LD0) || (st_q == ST_LD1);
		div_num   = (st_q == ST_LD1) ? p01_q : p00_q;
		out_load  = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// multiplier operands per micro-op
	always_comb begin
		unique case (op_q)
			OP_XPOS_UPD:  begin ma_w = k0_q; mb_w = y_q;   end
			OP_XVEL_UPD:  begin ma_w = k1_q; mb_w = y_q;   end
			OP_P00_UPD:   begin ma_w = k0_q; mb_w = p00_q; end
			OP_P01_UPD:   begin ma_w = k0_q; mb_w = p01_q; end
			OP_P11_UPD:   begin ma_w = k1_q; mb_w = p01_q; end
			OP_XPOS_PRED: begin ma_w = dt_q; mb_w = x1_q;  end
			OP_T_PRED:    begin ma_w = dt_q; mb_w = p11_q; end
			OP_P00_PART:  begin ma_w = dt_q; mb_w = p01_q; end
			default:      begin ma_w = dt_q; mb_w = t_q;   end
		endcase
		ma = ma_w[WORD_BITS-1] ? WORD_BITS'(-ma_w) : WORD_BITS'(ma_w);
		mb = mb_w[WORD_BITS-1] ? WORD_BITS'(-mb_w) : WORD_BITS'(mb_w);
	end

	// round half away from zero on the magnitude, then clamp
	always_comb begin
		rnd  = (prod_s1 + (PROD_BITS'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
		lim  = neg_s1 ? (PROD_BITS'(1) << (WORD_BITS-1))
		              : ((PROD_BITS'(1) << (WORD_BITS-1)) - PROD_BITS'(1));
		msat = rnd > lim;
		mq   = msat ? lim : rnd;
	end

	// writeback sums
	always_comb begin
		base = wide_t'(x0_q);
		addc = '0;
		sub  = 1'b0;
		unique case (op_q)
			OP_XPOS_UPD:  base = wide_t'(x0_q);
			OP_XVEL_UPD:  base = wide_t'(x1_q);
			OP_P00_UPD:   begin base = wide_t'(p00_q); sub = 1'b1; end
			OP_P01_UPD:   begin base = wide_t'(p01_q); sub = 1'b1; end
			OP_P11_UPD:   begin base = wide_t'(p11_q); sub = 1'b1; end
			OP_XPOS_PRED: begin base = wide_t'(x0_q); addc = wide_t'(dpos_q); end
			OP_T_PRED:    base = wide_t'(p01_q);
			OP_P00_PART:  base = wide_t'(p00_q);
			default:      begin base = acc_q; addc = wide_t'({1'b0, pvp_q}); end
		endcase
		wm       = wide_t'(m_q);
		main_sum = base + (sub ? -wm : wm) + addc;
		ss       = sat_s(main_sum);
		sv       = sat_v(main_sum);
		ax1      = sat_s(wide_t'(x1_q) + wide_t'(dvel_q));
		ap01     = sat_s(wide_t'(t_q) + wide_t'(pcov_q));
		ap11     = sat_v(wide_t'(p11_q) + wide_t'({1'b0, pvv_q}));
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= s_new;
			y_q <= y_new.val;
		end
		if (st_q == ST_DIV0 && div_done) begin
			k0_q <= div_res.val;
		end
		if (st_q == ST_DIV1 && div_done) begin
			k1_q <= div_res.val;
		end
		if (st_q == ST_MUL) begin
			prod_s1 <= ma * mb;
			neg_s1  <= ma_w[WORD_BITS-1] ^ mb_w[WORD_BITS-1];
		end
		if (st_q == ST_RND) begin
			m_q <= neg_s1 ? word_t'(-mq) : word_t'(mq);
		end
	end

	// filter state, micro-op counter and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q   <= '0;
			x1_q   <= '0;
			p00_q  <= RESET_VAR;
			p01_q  <= '0;
			p11_q  <= RESET_VAR;
			t_q    <= '0;
			acc_q  <= '0;
			op_q   <= OP_XPOS_UPD;
			flag_q <= 1'b0;
		end else begin
			if (accept) begin
				// zero S: skip straight to the prediction
				if (s_new == '0) begin
					op_q   <= OP_XPOS_PRED;
					flag_q <= 1'b1;
				end else begin
					op_q   <= OP_XPOS_UPD;
					flag_q <= y_new.sat;
				end
			end
			if ((st_q == ST_DIV0 || st_q == ST_DIV1) && div_done) begin
				flag_q <= flag_q | div_res.sat;
			end
			if (st_q == ST_RND) begin
				flag_q <= flag_q | msat;
			end
			if (st_q == ST_WB) begin
				op_q <= kf_op_t'(op_q + 4'd1);
				unique case (op_q)
					OP_XPOS_UPD: begin
						x0_q   <= ss.val;
						flag_q <= flag_q | ss.sat;
					end
					OP_XVEL_UPD: begin
						x1_q   <= ss.val;
						flag_q <= flag_q | ss.sat;
					end
					OP_P00_UPD: begin
						p00_q  <= sv.val;
						flag_q <= flag_q | sv.sat;
					end
					// new P01 held back: the P11 step still needs the old one
					OP_P01_UPD: begin
						t_q    <= ss.val;
						flag_q <= flag_q | ss.sat;
					end
					OP_P11_UPD: begin
						p11_q  <= sv.val;
						p01_q  <= t_q;
						flag_q <= flag_q | sv.sat;
					end
					OP_XPOS_PRED: begin
						x0_q   <= ss.val;
						x1_q   <= ax1.val;
						flag_q <= flag_q | ss.sat | ax1.sat;
					end
					OP_T_PRED: begin
						t_q    <= ss.val;
						flag_q <= flag_q | ss.sat;
					end
					OP_P00_PART: acc_q <= main_sum;
					default: begin
						p00_q  <= sv.val;
						p01_q  <= ap01.val;
						p11_q  <= ap11.val;
						flag_q <= flag_q | sv.sat | ap01.sat | ap11.sat;
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			est_pos_q     <= x0_q;
			est_vel_q     <= x1_q;
			out_var_pos_q <= p00_q[WORD_BITS-2:0];
			out_cov_q     <= p01_q;
			out_var_vel_q <= p11_q[WORD_BITS-2:0];
			sat_flag_q    <= flag_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign est_pos     = est_pos_q;
	assign est_vel     = est_vel_q;
	assign out_var_pos = out_var_pos_q;
	assign out_cov     = out_cov_q;
	assign out_var_vel = out_var_vel_q;
	assign sat_flag    = sat_flag_q;

	`KF_IMPLY_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready right after a beat")
	`KF_IMPLY(a_div_done_in_wait, div_done, st_q == ST_DIV0 || st_q == ST_DIV1, "stray divide done")
	`KF_ASSERT(a_var_nonneg, !p00_q[WORD_BITS-1] && !p11_q[WORD_BITS-1], "negative variance stored")
endmodule

// File: tb/tb.sv
// Self-checking testbench for the one-axis constant-velocity Kalman filter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kf_pkg::*;

	localparam longint SMAX_L = 64'sd2147483647;
	localparam longint SMIN_L = -64'sd2147483648;
	localparam int     SETTLE_CYC = 130;       // somewhat longer than one item takes in the filter
	localparam longint CYCLE_LIMIT = 2000000;

	// One output beat, field by field.
	typedef struct {
		word_t pos;
		word_t vel;
		var_t  var_pos;
		word_t cov;
		var_t  var_vel;
		logic  sat;
	} estimate_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	word_t cfg_data;
	logic  in_valid;
	logic  in_ready;
	word_t meas_pos;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t est_pos;
	word_t est_vel;
	var_t  out_var_pos;
	word_t out_cov;
	var_t  out_var_vel;
	logic  sat_flag;

	kalman_filter_pos_vel uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .meas_pos(meas_pos),
		.out_valid(out_valid), .out_ready(out_ready),
		.est_pos(est_pos), .est_vel(est_vel), .out_var_pos(out_var_pos),
		.out_cov(out_cov), .out_var_vel(out_var_vel), .sat_flag(sat_flag)
	);

	// Filter copy: settings and state, all held as wide signed integers.
	longint r_meas, q_pos, q_cov, q_vel, u_pos, u_vel, dt;
	longint x_pos, x_vel, p00_st, p01_st, p11_st;
	bit     clamp_hit;

	estimate_t pending_est[$];
	int        err_count = 0;
	longint    cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Fixed-point helpers mirroring the filter arithmetic
	// ---------------------------------------------------------------
	function automatic logic [127:0] magnitude(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	// Apply sign to a magnitude, clamping to the signed word range.
	function automatic longint signed_clamp(bit neg, logic [127:0] q);
		logic [127:0] lim;
		lim = neg ? 128'(SMAX_L + 1) : 128'(SMAX_L);
		if (q > lim) begin
			clamp_hit = 1'b1;
			q = lim;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Q16.16 product, rounded half away from zero.
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		p = magnitude(a) * magnitude(b);
		p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return signed_clamp((a < 0) != (b < 0), p);
	endfunction

	// round(num * 2^FRAC_BITS / den), den > 0.
	function automatic longint fx_div(longint num, longint den);
		logic [127:0] q;
		q = ((magnitude(num) << FRAC_BITS) + 128'(den >> 1)) / 128'(den);
		return signed_clamp(num < 0, q);
	endfunction

	function automatic longint clamp_word(longint v);
		if (v > SMAX_L) begin
			clamp_hit = 1'b1;
			return SMAX_L;
		end
		if (v < SMIN_L) begin
			clamp_hit = 1'b1;
			return SMIN_L;
		end
		return v;
	endfunction

	function automatic longint clamp_var(longint v);
		if (v > SMAX_L) begin
			clamp_hit = 1'b1;
			return SMAX_L;
		end
		if (v < 0) begin
			clamp_hit = 1'b1;
			return 0;
		end
		return v;
	endfunction

	// Measurement update followed by prediction; returns the new estimate.
	function automatic estimate_t kalman_advance(word_t z);
		estimate_t e;
		longint x0, x1, p00, p01, p11, s, k0, k1, y, n00, n01, n11, t;
		x0 = x_pos;
		x1 = x_vel;
		p00 = p00_st;
		p01 = p01_st;
		p11 = p11_st;
		s = p00 + r_meas;
		clamp_hit = 1'b0;
		if (s == 0) begin
			// zero innovation variance: update skipped, flag raised
			clamp_hit = 1'b1;
		end else begin
			k0 = fx_div(p00, s);
			k1 = fx_div(p01, s);
			y = clamp_word(longint'(z) - x0);
			x0 = clamp_word(x0 + fx_mul(k0, y));
			x1 = clamp_word(x1 + fx_mul(k1, y));
			n00 = clamp_var(p00 - fx_mul(k0, p00));
			n01 = clamp_word(p01 - fx_mul(k0, p01));
			n11 = clamp_var(p11 - fx_mul(k1, p01));
			p00 = n00;
			p01 = n01;
			p11 = n11;
		end
		x0 = clamp_word(x0 + fx_mul(dt, x1) + u_pos);
		x1 = clamp_word(x1 + u_vel);
		t = clamp_word(p01 + fx_mul(dt, p11));
		p00 = clamp_var(p00 + fx_mul(dt, p01) + fx_mul(dt, t) + q_pos);
		p01 = clamp_word(t + q_cov);
		p11 = clamp_var(p11 + q_vel);
		x_pos = x0;
		x_vel = x1;
		p00_st = p00;
		p01_st = p01;
		p11_st = p11;
		e.pos = word_t'(x0);
		e.vel = word_t'(x1);
		e.var_pos = var_t'(p00);
		e.cov = word_t'(p01);
		e.var_vel = var_t'(p11);
		e.sat = clamp_hit;
		return e;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Register write; only issued while the filter is idle.
	task automatic write_reg(cfg_reg_t idx, word_t val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MEAS_VAR:     r_meas = longint'(var_t'(val));
			REG_PROC_VAR_POS: q_pos = longint'(var_t'(val));
			REG_PROC_COV:     q_cov = longint'(val);
			REG_PROC_VAR_VEL: q_vel = longint'(var_t'(val));
			REG_DRIVE_POS:    u_pos = longint'(val);
			REG_DRIVE_VEL:    u_vel = longint'(val);
			REG_STEP_DT:      dt = longint'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(word_t r, word_t qp, word_t qc, word_t qv,
			word_t up, word_t uv, word_t step);
		write_reg(REG_MEAS_VAR, r);
		write_reg(REG_PROC_VAR_POS, qp);
		write_reg(REG_PROC_COV, qc);
		write_reg(REG_PROC_VAR_VEL, qv);
		write_reg(REG_DRIVE_POS, up);
		write_reg(REG_DRIVE_VEL, uv);
		write_reg(REG_STEP_DT, step);
	endtask

	// Send one measurement beat. Called at a falling edge; returns at one with
	// in_valid still high, so back-to-back beats keep valid asserted.
	task automatic send_meas(word_t z);
		in_valid <= 1'b1;
		meas_pos <= z;
		do @(posedge clk); while (!in_ready);
		pending_est = {pending_est, kalman_advance(z)};
		@(negedge clk);
	endtask

	task automatic hold_off(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Stop sending and wait until every expected beat has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_est.size() != 0) @(negedge clk);
	endtask

	// Drain, then let the pipeline go fully quiet before touching registers.
	task automatic settle();
		drain();
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	function automatic word_t rand_word();
		return word_t'($urandom());
	endfunction

	// Mostly sensor-like positions near the estimate, some wild ones.
	function automatic word_t rand_meas();
		case ($urandom_range(0, 9))
			0, 1: return rand_word();
			2:    return word_t'($urandom_range(0, 1) ? SMAX_L : SMIN_L);
			default: return word_t'(x_pos + $signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	// Random bursts of measurements with random gaps in between.
	task automatic random_burst_run(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				send_meas(rand_meas());
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0)
				hold_off($urandom_range(1, 150));
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Field extremes with the register values left at reset.
	task automatic test_reset_defaults();
		send_meas(word_t'(0));
		send_meas(word_t'(SMAX_L));
		send_meas(word_t'(SMIN_L));
		send_meas(word_t'(-1));
		send_meas(word_t'(1));
		send_meas(word_t'(32'h0001_0000));
		send_meas(word_t'(32'hAAAA_AAAA));
		send_meas(word_t'(32'h5555_5555));
		settle();
	endtask

	// R = 0 and no noise: P00 collapses to zero, and then S = 0 skips the update.
	task automatic test_zero_innovation();
		write_all(word_t'(0), word_t'(0), word_t'(0), word_t'(0),
			word_t'(0), word_t'(0), word_t'(0));
		send_meas(word_t'(32'h0003_0000));
		send_meas(word_t'(32'h0005_0000));
		send_meas(word_t'(SMIN_L));
		settle();
	endtask

	// Extreme register settings: huge time step, drives and noise.
	task automatic test_register_extremes();
		write_all(word_t'(SMAX_L), word_t'(SMAX_L), word_t'(SMAX_L), word_t'(SMAX_L),
			word_t'(SMAX_L), word_t'(SMAX_L), word_t'(SMAX_L));
		send_meas(word_t'(SMAX_L));
		send_meas(word_t'(SMIN_L));
		send_meas(word_t'(0));
		settle();
		write_all(word_t'(1), word_t'(0), word_t'(SMIN_L), word_t'(0),
			word_t'(SMIN_L), word_t'(SMIN_L), word_t'(SMIN_L));
		send_meas(word_t'(SMIN_L));
		send_meas(word_t'(SMAX_L));
		send_meas(word_t'(-1));
		settle();
		// high bits set above the 31-bit registers must be dropped
		write_all(word_t'(32'hFFFF_FFFF), word_t'(32'h8000_0001), word_t'(-1),
			word_t'(32'h8000_0000), word_t'(1), word_t'(-1), word_t'(-32'sh0001_0000));
		send_meas(word_t'(32'h1234_5678));
		send_meas(word_t'(32'h8765_4321));
		settle();
	endtask

	// Several random settings, small ones mostly, each with two random runs.
	task automatic test_random_tracking();
		int ph;
		for (ph = 0; ph < 8; ph++) begin
			if (ph % 3 == 0)
				write_all(rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word());
			else
				write_all(word_t'($urandom_range(0, 1 << 18)),
					word_t'($urandom_range(0, 1 << 12)),
					word_t'($signed($urandom_range(0, 1 << 10)) - (1 << 9)),
					word_t'($urandom_range(0, 1 << 12)),
					word_t'($signed($urandom_range(0, 1 << 16)) - (1 << 15)),
					word_t'($signed($urandom_range(0, 1 << 12)) - (1 << 11)),
					word_t'($urandom_range(0, 1 << 17)));
			random_burst_run(100);
			// sender pauses until everything is back, then resumes
			drain();
			random_burst_run(100);
			settle();
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stall pattern in four modes, switched by the running count of cycles
	// ---------------------------------------------------------------
	logic [1:0] stall_mode = 2'd0;
	always @(negedge clk) begin
		if (cycle_count % 256 == 0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0:    out_ready <= 1'b1;                        // no stalls
			2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
			2'd2:    out_ready <= ($urandom_range(0, 9) == 0); // long stalls
			default: out_ready <= (cycle_count % 7 < 4);
		endcase
	end

	// ---------------------------------------------------------------
	// Result checker: every accepted output beat against the oldest estimate
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_est.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("ERROR: unexpected output beat pos=%h", est_pos);
			end else begin
				e = pending_est.pop_front();
				if (est_pos !== e.pos || est_vel !== e.vel || out_var_pos !== e.var_pos ||
						out_cov !== e.cov || out_var_vel !== e.var_vel ||
						sat_flag !== e.sat) begin
					err_count++;
					if (err_count <= 10)
						$display("ERROR: mismatch exp pos=%h vel=%h p00=%h p01=%h p11=%h sat=%b",
							e.pos, e.vel, e.var_pos, e.cov, e.var_vel, e.sat,
							" got pos=%h vel=%h p00=%h p01=%h p11=%h sat=%b",
							est_pos, est_vel, out_var_pos, out_cov, out_var_vel, sat_flag);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		meas_pos = '0;
		// filter copy at its reset values
		r_meas = 64'sd65536;
		q_pos = 0;
		q_cov = 0;
		q_vel = 0;
		u_pos = 0;
		u_vel = 0;
		dt = 64'sd65536;
		x_pos = 0;
		x_vel = 0;
		p00_st = 64'sd65536000;
		p01_st = 0;
		p11_st = 64'sd65536000;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_zero_innovation();
		test_register_extremes();
		test_random_tracking();
		settle();

		if (err_count == 0 && pending_est.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
